// File: design/stpq_pkg.sv
package stpq_pkg;

    // queue depth and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 8;

    // action codes
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_LIST   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic list_step;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic list_go;
        logic list_last;
    } t_sts;

endpackage

// File: design/stpq_ctrl.sv
module stpq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  stpq_pkg::t_sts i_sts,
    output stpq_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_sts.list_go ? S_LIST : S_IDLE;
            end
            S_LIST: begin
                if (i_sts.list_last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign busy            = (r_state != S_IDLE);
    assign o_cmd.load      = start && (r_state == S_IDLE);
    assign o_cmd.exec      = (r_state == S_EXEC);
    assign o_cmd.list_step = (r_state == S_LIST);

    // assertions
    a_list_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> ($past(r_state) == S_EXEC || $past(r_state) == S_LIST))
        else $error("list walk entered without execute");
    a_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("accepted item not executed");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.exec, o_cmd.list_step}))
        else $error("more than one command active");

endmodule

// File: design/stpq_dp.sv
module stpq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stpq_pkg::t_cmd                i_cmd,
    output stpq_pkg::t_sts                o_sts,
    input  logic [1:0]                    i_action,
    input  logic [stpq_pkg::ID_W-1:0]     i_task_id,
    input  logic [stpq_pkg::PRIO_W-1:0]   i_task_priority,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic [stpq_pkg::ID_W-1:0]     o_result_id,
    output logic [stpq_pkg::PRIO_W-1:0]   o_result_priority,
    output logic                          o_last
);

    localparam int N = stpq_pkg::CAPACITY;

    // entry registers, kept sorted, head at index 0
    logic [stpq_pkg::ID_W-1:0]   r_ids   [N];
    logic [stpq_pkg::PRIO_W-1:0] r_prios [N];
    logic [stpq_pkg::ID_W-1:0]   n_ids   [N];
    logic [stpq_pkg::PRIO_W-1:0] n_prios [N];
    logic [stpq_pkg::CNT_W-1:0]  r_count;
    logic [stpq_pkg::CNT_W-1:0]  n_count;

    // captured item and list walk index
    logic [1:0]                  r_action;
    logic [stpq_pkg::ID_W-1:0]   r_id;
    logic [stpq_pkg::PRIO_W-1:0] r_prio;
    logic [stpq_pkg::IDX_W-1:0]  r_idx;

    // result registers
    logic                        r_strobe;
    logic [1:0]                  r_status;
    logic [stpq_pkg::ID_W-1:0]   r_rid;
    logic [stpq_pkg::PRIO_W-1:0] r_rprio;
    logic                        r_last;
    logic                        n_strobe;
    logic [1:0]                  n_status;
    logic [stpq_pkg::ID_W-1:0]   n_rid;
    logic [stpq_pkg::PRIO_W-1:0] n_rprio;
    logic                        n_last;

    logic [N-1:0] valid;
    logic [N-1:0] ge;
    logic [N-1:0] match;
    logic [N-1:0] first;
    logic [N-1:0] after;
    logic         found;
    logic         full;
    logic         empty;
    logic         do_add;
    logic         do_del;
    logic         list_last;
    logic [stpq_pkg::ID_W-1:0]   sel_id;
    logic [stpq_pkg::PRIO_W-1:0] sel_prio;

    // per-entry compares
    always_comb begin
        for (int i = 0; i < N; i++) begin
            valid[i] = (stpq_pkg::CNT_W'(i) < r_count);
            ge[i]    = valid[i] && (r_prios[i] >= r_prio);
            match[i] = valid[i] && (r_ids[i] == r_id);
        end
    end

    // first match and the span from removal point to the tail
    // for remove, after is the running or of match, so it marks earlier hits
    always_comb begin
        first[0] = match[0];
        after[0] = (r_action == stpq_pkg::ACT_POP) ? 1'b1 : match[0];
        for (int i = 1; i < N; i++) begin
            first[i] = match[i] && !after[i-1];
            after[i] = (r_action == stpq_pkg::ACT_POP) ? 1'b1 : (after[i-1] | match[i]);
        end
    end

    // removed entry: head for pop, first match for remove
    always_comb begin
        sel_id   = '0;
        sel_prio = '0;
        for (int i = 0; i < N; i++) begin
            if (first[i]) begin
                sel_id   = sel_id | r_ids[i];
                sel_prio = sel_prio | r_prios[i];
            end
        end
        if (r_action == stpq_pkg::ACT_POP) begin
            sel_id   = r_ids[0];
            sel_prio = r_prios[0];
        end
    end

    assign found     = |match;
    assign full      = (r_count == stpq_pkg::CNT_W'(N));
    assign empty     = (r_count == '0);
    assign do_add    = i_cmd.exec && (r_action == stpq_pkg::ACT_ADD) && !full;
    assign do_del    = i_cmd.exec &&
                       (((r_action == stpq_pkg::ACT_POP) && !empty) ||
                        ((r_action == stpq_pkg::ACT_REMOVE) && found));
    assign list_last = ((stpq_pkg::CNT_W'(r_idx) + stpq_pkg::CNT_W'(1)) == r_count);

    // entry update: insert after all entries of at least equal priority, or close a gap
    always_comb begin
        n_count = r_count;
        for (int i = 0; i < N; i++) begin
            n_ids[i]   = r_ids[i];
            n_prios[i] = r_prios[i];
        end
        if (do_add) begin
            n_count = r_count + stpq_pkg::CNT_W'(1);
            for (int i = 0; i < N; i++) begin
                if (!ge[i]) begin
                    if (i == 0 || ge[(i == 0) ? 0 : i-1]) begin
                        n_ids[i]   = r_id;
                        n_prios[i] = r_prio;
                    end else begin
                        n_ids[i]   = r_ids[(i == 0) ? 0 : i-1];
                        n_prios[i] = r_prios[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end else if (do_del) begin
            n_count = r_count - stpq_pkg::CNT_W'(1);
            for (int i = 0; i < N - 1; i++) begin
                if (after[i]) begin
                    n_ids[i]   = r_ids[i+1];
                    n_prios[i] = r_prios[i+1];
                end
            end
        end
    end

    // result beat
    always_comb begin
        n_strobe = 1'b0;
        n_status = stpq_pkg::ST_OK;
        n_rid    = '0;
        n_rprio  = '0;
        n_last   = 1'b1;
        if (i_cmd.exec) begin
            unique case (r_action)
                stpq_pkg::ACT_ADD: begin
                    n_strobe = 1'b1;
                    n_status = full ? stpq_pkg::ST_FULL : stpq_pkg::ST_OK;
                end
                stpq_pkg::ACT_POP: begin
                    n_strobe = 1'b1;
                    if (empty) begin
                        n_status = stpq_pkg::ST_EMPTY;
                    end else begin
                        n_rid   = sel_id;
                        n_rprio = sel_prio;
                    end
                end
                stpq_pkg::ACT_REMOVE: begin
                    n_strobe = 1'b1;
                    if (!found) begin
                        n_status = stpq_pkg::ST_NOT_FOUND;
                    end else begin
                        n_rid   = sel_id;
                        n_rprio = sel_prio;
                    end
                end
                default: begin
                    // list: only an empty queue answers here
                    n_strobe = empty;
                    n_status = stpq_pkg::ST_EMPTY;
                end
            endcase
        end else if (i_cmd.list_step) begin
            n_strobe = 1'b1;
            n_rid    = r_ids[r_idx];
            n_rprio  = r_prios[r_idx];
            n_last   = list_last;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            r_ids[i]   <= n_ids[i];
            r_prios[i] <= n_prios[i];
        end
        if (i_cmd.load) begin
            r_action <= i_action;
            r_id     <= i_task_id;
            r_prio   <= i_task_priority;
        end
        if (i_cmd.exec) begin
            r_idx <= '0;
        end else if (i_cmd.list_step) begin
            r_idx <= r_idx + stpq_pkg::IDX_W'(1);
        end
        r_status <= n_status;
        r_rid    <= n_rid;
        r_rprio  <= n_rprio;
        r_last   <= n_last;
    end

    assign o_sts.list_go     = (r_action == stpq_pkg::ACT_LIST) && !empty;
    assign o_sts.list_last   = list_last;
    assign o_strobe          = r_strobe;
    assign o_status          = r_status;
    assign o_result_id       = r_rid;
    assign o_result_priority = r_rprio;
    assign o_last            = r_last;

    // assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stpq_pkg::CNT_W'(N))
        else $error("entry count above capacity");
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_add |=> (r_count == $past(r_count) + stpq_pkg::CNT_W'(1)))
        else $error("add did not grow the queue");
    a_list_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.list_step |-> (stpq_pkg::CNT_W'(r_idx) < r_count))
        else $error("list walk past the tail");
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status == stpq_pkg::ST_FULL) |-> full)
        else $error("full reported with room left");

endmodule

// File: design/sorted_priority_task_queue.sv
// sorted priority task queue
// keeps up to 16 tasks (id, priority) ordered by priority, highest first;
// equal priorities stay in arrival order.
// command channel: an item (i_action, i_task_id, i_task_priority) is taken at
// a clock edge with start high and busy low; busy stays high until the item
// is finished.
// result channel: each result beat is on o_status, o_result_id,
// o_result_priority and o_last for one cycle, marked by o_strobe; o_last
// flags the final beat of an item. the receiver cannot stall.
// add, pop and remove give one beat each; the item is captured at acceptance,
// then the parallel compare and shift over the entry registers happens in the
// execute state, and the beat is registered from it.
// list: one beat per entry, head first, from the list walk state that follows
// execute; an empty queue gives a single empty-status beat from execute.
// a new item may be started in the cycle its last beat is shown.
// reset (i_rst_n low, synchronous) empties the queue and drops any beat.
module sorted_priority_task_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_action,
    input  logic [stpq_pkg::ID_W-1:0]     i_task_id,
    input  logic [stpq_pkg::PRIO_W-1:0]   i_task_priority,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic [stpq_pkg::ID_W-1:0]     o_result_id,
    output logic [stpq_pkg::PRIO_W-1:0]   o_result_priority,
    output logic                          o_last
);

    stpq_pkg::t_cmd cmd;
    stpq_pkg::t_sts sts;

    // sequencer
    stpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // entry registers and result path
    stpq_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_action),
        .i_task_id         (i_task_id),
        .i_task_priority   (i_task_priority),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_result_id       (o_result_id),
        .o_result_priority (o_result_priority),
        .o_last            (o_last)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // watchdog: a list of a full queue plus the longest gap stays far below this
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct {
        logic [1:0]                  status;
        logic [stpq_pkg::ID_W-1:0]   id;
        logic [stpq_pkg::PRIO_W-1:0] prio;
        logic                        last;
    } t_task_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  i_action;
    logic [stpq_pkg::ID_W-1:0]   i_task_id;
    logic [stpq_pkg::PRIO_W-1:0] i_task_priority;
    logic                        o_strobe;
    logic [1:0]                  o_status;
    logic [stpq_pkg::ID_W-1:0]   o_result_id;
    logic [stpq_pkg::PRIO_W-1:0] o_result_priority;
    logic                        o_last;

    // predicted queue contents, head first
    logic [stpq_pkg::ID_W-1:0]   held_ids[$];
    logic [stpq_pkg::PRIO_W-1:0] held_prios[$];
    t_task_result                expected_beats[$];

    int  mismatch_count = 0;
    int  stall_cycles = 0;
    bit  no_gaps = 1'b0;

    sorted_priority_task_queue dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_task_id         (i_task_id),
        .i_task_priority   (i_task_priority),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_result_id       (o_result_id),
        .o_result_priority (o_result_priority),
        .o_last            (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void push_beat(input logic [1:0] status,
                                      input logic [stpq_pkg::ID_W-1:0] id,
                                      input logic [stpq_pkg::PRIO_W-1:0] prio,
                                      input logic last);
        t_task_result r;
        r.status = status;
        r.id     = id;
        r.prio   = prio;
        r.last   = last;
        expected_beats.push_back(r);
    endfunction

    // queue behavior for one accepted command
    function automatic void predict_queue_action(input logic [1:0] act,
                                                 input logic [stpq_pkg::ID_W-1:0] id,
                                                 input logic [stpq_pkg::PRIO_W-1:0] prio);
        int pos;
        case (act)
            stpq_pkg::ACT_ADD: begin
                if (held_ids.size() >= stpq_pkg::CAPACITY) begin
                    push_beat(stpq_pkg::ST_FULL, '0, '0, 1'b1);
                end else begin
                    // goes behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < held_ids.size() && held_prios[pos] >= prio)
                        pos++;
                    held_ids.insert(pos, id);
                    held_prios.insert(pos, prio);
                    push_beat(stpq_pkg::ST_OK, '0, '0, 1'b1);
                end
            end
            stpq_pkg::ACT_POP: begin
                if (held_ids.size() == 0) begin
                    push_beat(stpq_pkg::ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    push_beat(stpq_pkg::ST_OK, held_ids[0], held_prios[0], 1'b1);
                    void'(held_ids.pop_front());
                    void'(held_prios.pop_front());
                end
            end
            stpq_pkg::ACT_REMOVE: begin
                pos = -1;
                for (int i = 0; i < held_ids.size(); i++) begin
                    if (pos < 0 && held_ids[i] == id)
                        pos = i;
                end
                if (pos < 0) begin
                    push_beat(stpq_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                end else begin
                    push_beat(stpq_pkg::ST_OK, held_ids[pos], held_prios[pos], 1'b1);
                    held_ids.delete(pos);
                    held_prios.delete(pos);
                end
            end
            default: begin
                if (held_ids.size() == 0) begin
                    push_beat(stpq_pkg::ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < held_ids.size(); i++)
                        push_beat(stpq_pkg::ST_OK, held_ids[i], held_prios[i],
                                  i == held_ids.size() - 1);
                end
            end
        endcase
    endfunction

    // mostly short gaps, a few long ones, none while no_gaps is set
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    // drive one command beat, wait for it to be taken, then maybe idle
    task automatic send_item(input logic [1:0] act, input logic [stpq_pkg::ID_W-1:0] id,
                             input logic [stpq_pkg::PRIO_W-1:0] prio);
        int gap;
        start           <= 1'b1;
        i_action        <= act;
        i_task_id       <= id;
        i_task_priority <= prio;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_queue_action(act, id, prio);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            // fields wander while start is low; they must be ignored
            i_action        <= 2'($urandom);
            i_task_id       <= 16'($urandom);
            i_task_priority <= 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // pop, remove and list on an empty queue
    task automatic test_empty_queue();
        send_item(stpq_pkg::ACT_POP, 16'h1234, 8'h12);
        send_item(stpq_pkg::ACT_REMOVE, 16'h0000, 8'h00);
        send_item(stpq_pkg::ACT_LIST, 16'hFFFF, 8'hFF);
    endtask

    // fill with extremes, ties and a duplicate id, then overflow and list
    task automatic test_fill_to_capacity();
        send_item(stpq_pkg::ACT_ADD, 16'h0000, 8'h00);
        send_item(stpq_pkg::ACT_ADD, 16'hFFFF, 8'hFF);
        send_item(stpq_pkg::ACT_ADD, 16'hAAAA, 8'h80);
        send_item(stpq_pkg::ACT_ADD, 16'h5555, 8'h80);
        send_item(stpq_pkg::ACT_ADD, 16'h0002, 8'h80);
        send_item(stpq_pkg::ACT_ADD, 16'hAAAA, 8'h10);
        for (int i = 0; i < stpq_pkg::CAPACITY - 6; i++)
            send_item(stpq_pkg::ACT_ADD, 16'h0100 + 16'(i), 8'($urandom));
        send_item(stpq_pkg::ACT_ADD, 16'h7777, 8'hFF);
        send_item(stpq_pkg::ACT_LIST, 16'h0000, 8'h00);
    endtask

    // first match wins on a duplicate id, a miss changes nothing; then pops and an add
    task automatic test_remove_and_pop();
        send_item(stpq_pkg::ACT_REMOVE, 16'hAAAA, 8'h00);
        send_item(stpq_pkg::ACT_REMOVE, 16'hABCD, 8'h00);
        send_item(stpq_pkg::ACT_POP, 16'h0000, 8'h00);
        send_item(stpq_pkg::ACT_POP, 16'h0000, 8'h00);
        send_item(stpq_pkg::ACT_ADD, 16'h0003, 8'hFF);
    endtask

    // random traffic swinging between empty and full
    task automatic test_random_traffic(input int n_items);
        bit                          filling;
        int                          r;
        int                          cnt;
        logic [1:0]                  act;
        logic [stpq_pkg::ID_W-1:0]   id;
        logic [stpq_pkg::PRIO_W-1:0] prio;
        filling = 1'b1;
        for (int n = 0; n < n_items; n++) begin
            if (n % 30 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            cnt = held_ids.size();
            if (cnt == 0)
                filling = 1'b1;
            else if (cnt == stpq_pkg::CAPACITY && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if ($urandom_range(0, 19) == 0)
                filling = !filling;
            r = $urandom_range(0, 99);
            if (filling)
                act = (r < 60) ? stpq_pkg::ACT_ADD :
                      (r < 75) ? stpq_pkg::ACT_POP :
                      (r < 90) ? stpq_pkg::ACT_REMOVE : stpq_pkg::ACT_LIST;
            else
                act = (r < 20) ? stpq_pkg::ACT_ADD :
                      (r < 55) ? stpq_pkg::ACT_POP :
                      (r < 90) ? stpq_pkg::ACT_REMOVE : stpq_pkg::ACT_LIST;
            // small id pool gives duplicates and remove hits
            if (act == stpq_pkg::ACT_REMOVE && cnt > 0 && $urandom_range(0, 9) < 7)
                id = held_ids[$urandom_range(0, cnt - 1)];
            else if ($urandom_range(0, 1) == 0)
                id = 16'($urandom_range(0, 15));
            else
                id = 16'($urandom);
            r = $urandom_range(0, 99);
            if (r < 30)
                prio = 8'($urandom_range(0, 3));
            else if (r < 40)
                prio = 8'hFF;
            else
                prio = 8'($urandom);
            send_item(act, id, prio);
        end
        no_gaps = 1'b0;
    endtask

    // compare every result beat with the oldest prediction
    always @(posedge i_clk) begin : check_beats
        t_task_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat status %0d id %h prio %h last %b",
                                          o_status, o_result_id, o_result_priority, o_last));
            end else begin
                want = expected_beats.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_result_id !== want.id)
                    report_mismatch($sformatf("id %h, want %h", o_result_id, want.id));
                if (o_result_priority !== want.prio)
                    report_mismatch($sformatf("priority %h, want %h",
                                              o_result_priority, want.prio));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", o_last, want.last));
            end
        end
    end

    // give up when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_action        = stpq_pkg::ACT_ADD;
        i_task_id       = '0;
        i_task_priority = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_queue();
        test_fill_to_capacity();
        test_remove_and_pop();
        test_random_traffic(250);

        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
